[src/box_muller_gaussian_sampler_core_defines.svh]
// Assertion macros shared by the sampler RTL.
`ifndef BOX_MULLER_GAUSSIAN_SAMPLER_CORE_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BMG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define BMG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bmg_pkg.sv]
// Shared types, constants and tables of the Box-Muller sampler.
package bmg_pkg;

    localparam int FracBits     = 16;
    localparam int UniformWidth = 32;
    localparam int SampleWidth  = 32;
    localparam int CfgDataWidth = 32;
    localparam int CfgIndexWidth = 2;

    // Register indexes of the configuration port.
    localparam logic [CfgIndexWidth-1:0] RegOutputMode   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] RegMeanValue    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] RegStdDeviation = 2'd2;

    localparam logic [30:0] SigmaReset = 31'(64'd1 << FracBits);

    // Fixed-point constants.
    localparam logic [31:0]        Ln2Q32     = 32'd2977044472;
    localparam logic [30:0]        HalfPiQ30  = 31'd1686629713;
    localparam logic signed [31:0] CordicGain = 32'sd652032874;
    localparam logic signed [65:0] RoundHalf  = 66'sd134217728;

    // Pipeline stage map.
    localparam int CordicFirst = 1;
    localparam int CordicSteps = 30;
    localparam int NormStage   = 1;
    localparam int LogFirst    = 2;
    localparam int LogLast     = 33;
    localparam int SineStage   = 31;
    localparam int LnStage     = 34;
    localparam int ScaleStage  = 35;
    localparam int SqrtFirst   = 36;
    localparam int SqrtLast    = 67;
    localparam int ZStage      = 68;
    localparam int SigmaStage  = 69;
    localparam int RoundStage  = 70;
    localparam int NumStages   = 71;
    localparam int LastStage   = NumStages - 1;

    typedef enum logic [1:0] {
        QuadFirst,
        QuadSecond,
        QuadThird,
        QuadFourth
    } quad_t;

    typedef struct packed {
        logic [31:0]        k1;
        logic [5:0]         lz;
        logic [5:0]         ipart;
        logic [31:0]        lx;
        logic [31:0]        frac;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        quad_t              quad;
        logic signed [32:0] sine;
        logic [37:0]        ph;
        logic [63:0]        pl;
        logic [63:0]        sv;
        logic [63:0]        sres;
        logic signed [33:0] z;
        logic signed [65:0] prod;
        logic signed [37:0] t;
    } stage_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd843314857;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043837;
            5'd3:    v = 32'sd133525159;
            5'd4:    v = 32'sd67021687;
            5'd5:    v = 32'sd33543516;
            5'd6:    v = 32'sd16775851;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194283;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048576;
            default: v = $signed(32'd1 << (5'd30 - i));
        endcase
        return v;
    endfunction

endpackage

[src/bmg_in_if.sv]
// Input channel carrying one pair of uniform codes per item.
interface bmg_in_if;
    logic                                valid;
    logic                                ready;
    logic [bmg_pkg::UniformWidth-1:0]    uniform_first;
    logic [bmg_pkg::UniformWidth-1:0]    uniform_second;

    modport source(output valid, output uniform_first, output uniform_second, input ready);
    modport sink(input valid, input uniform_first, input uniform_second, output ready);
endinterface

[src/bmg_out_if.sv]
// Output channel carrying one sample per item.
interface bmg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bmg_pkg::SampleWidth-1:0] sample_value;
    logic                                saturated_flag;

    modport source(output valid, output sample_value, output saturated_flag, input ready);
    modport sink(input valid, input sample_value, input saturated_flag, output ready);
endinterface

[src/box_muller_gaussian_sampler_core.sv]
// Box-Muller sampler: one item per clock while the pipeline is not halted.
//
// This block turns each item of two 32-bit uniform codes into one signed Q15.16
// sample. In normal mode it returns mean + sigma * sqrt(-2 ln u1) * sin(2 pi u2),
// saturated to 32 bits with saturated_flag raised on a clip; in passthrough mode
// it returns u1 rounded to the output format. The datapath is a 71-stage
// pipeline followed by an output register. The accepting edge loads the first
// stage, from which each item moves up through the stages to the output register,
// and a new item is taken in every clock while the stages advance. The logarithm
// uses one stage per result bit of a repeated-squaring unit (32 stages), the
// square root one stage per root bit (32 stages), and the sine a 30-step CORDIC
// that runs alongside the logarithm. All stages advance together; they halt
// only when the output register holds an unread result and the last stage
// holds an item. While the output waits, an empty last stage lets the whole
// pipeline move up by one, so the input stays open until an item reaches the
// last stage.
// Configuration registers are written through a plain write port and should
// be changed only while no item is in flight.
`include "box_muller_gaussian_sampler_core_defines.svh"

module box_muller_gaussian_sampler_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [bmg_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [bmg_pkg::CfgDataWidth-1:0]     cfg_data,
    bmg_in_if.sink                               uniforms,
    bmg_out_if.source                            samples
);

    // Configuration registers.
    logic               mode_reg;
    logic signed [31:0] mean_reg;
    logic [30:0]        sigma_reg;

    // Pipeline registers; valid bits travel beside the payload.
    bmg_pkg::stage_t stage_reg  [bmg_pkg::NumStages];
    bmg_pkg::stage_t stage_next [bmg_pkg::NumStages];
    logic [bmg_pkg::NumStages-1:0] stage_valid_reg;

    // Output register.
    logic                  out_valid_reg;
    logic signed [31:0]    out_sample_reg;
    logic signed [31:0]    out_sample_next;
    logic                  out_sat_reg;
    logic                  out_sat_next;

    // The whole pipeline moves when the output register can take a result or
    // when the last stage holds nothing to hand over.
    logic advance;

    assign advance = !out_valid_reg || samples.ready || !stage_valid_reg[bmg_pkg::LastStage];

    assign uniforms.ready         = advance;
    assign samples.valid          = out_valid_reg;
    assign samples.sample_value   = out_sample_reg;
    assign samples.saturated_flag = out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            mean_reg  <= '0;
            sigma_reg <= bmg_pkg::SigmaReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bmg_pkg::RegOutputMode:   mode_reg  <= cfg_data[0];
                bmg_pkg::RegMeanValue:    mean_reg  <= $signed(cfg_data);
                bmg_pkg::RegStdDeviation: sigma_reg <= cfg_data[30:0];
                default:                  ;
            endcase
        end
    end

    // Counts leading zeros of the odd 33-bit value 2*k1+1.
    function automatic logic [5:0] lead_zeros(input logic [32:0] m);
        logic [5:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 32; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                n     = 6'(32 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    for (genvar k = 0; k < bmg_pkg::NumStages; k++)
    begin : g_stage
        localparam int CordicIdx =
            (k >= bmg_pkg::CordicFirst && k < bmg_pkg::CordicFirst + bmg_pkg::CordicSteps)
            ? k - bmg_pkg::CordicFirst : 0;
        localparam int LogBit =
            (k >= bmg_pkg::LogFirst && k <= bmg_pkg::LogLast) ? bmg_pkg::LogLast - k : 0;
        localparam int SqrtIdx =
            (k >= bmg_pkg::SqrtFirst && k <= bmg_pkg::SqrtLast) ? k - bmg_pkg::SqrtFirst : 0;
        localparam logic [63:0] SqrtBit = 64'd1 << (62 - 2 * SqrtIdx);

        if (k == 0)
        begin : g_entry
            // Entry: leading-zero count for the log and phase scaling for the sine.
            always_comb
            begin
                logic [32:0] m1;
                logic [30:0] r;
                logic [61:0] ang;
                stage_next[k] = '0;
                m1  = {uniforms.uniform_first, 1'b1};
                r   = {uniforms.uniform_second[29:0], 1'b1};
                ang = 62'(r) * 62'(bmg_pkg::HalfPiQ30);
                stage_next[k].k1   = uniforms.uniform_first;
                stage_next[k].lz   = lead_zeros(m1);
                stage_next[k].quad = bmg_pkg::quad_t'(uniforms.uniform_second[31:30]);
                stage_next[k].cx   = bmg_pkg::CordicGain;
                stage_next[k].cy   = '0;
                stage_next[k].cz   = $signed({1'b0, ang[61:31]});
            end
        end
        else
        begin : g_work
            always_comb
            begin
                bmg_pkg::stage_t    p;
                logic [32:0]        m1;
                logic [32:0]        sh;
                logic signed [31:0] dx;
                logic signed [31:0] dy;
                logic [63:0]        sq;
                logic [32:0]        tq;
                logic [31:0]        lo;
                logic [5:0]         lh;
                logic [39:0]        w;
                logic [63:0]        trial;
                logic signed [65:0] zp;
                logic signed [65:0] rs;
                p = stage_reg[k-1];
                stage_next[k] = p;
                m1    = '0;
                sh    = '0;
                dx    = '0;
                dy    = '0;
                sq    = '0;
                tq    = '0;
                lo    = '0;
                lh    = '0;
                w     = '0;
                trial = '0;
                zp    = '0;
                rs    = '0;

                if (k == bmg_pkg::NormStage)
                begin
                    // Normalize the mantissa so that its top bit lands on bit 31.
                    m1 = {p.k1, 1'b1};
                    sh = m1 << p.lz;
                    stage_next[k].lx    = sh[32:1];
                    stage_next[k].ipart = p.lz + 6'd1;
                    stage_next[k].frac  = '0;
                end

                if (k >= bmg_pkg::CordicFirst
                    && k < bmg_pkg::CordicFirst + bmg_pkg::CordicSteps)
                begin
                    dx = p.cy >>> CordicIdx;
                    dy = p.cx >>> CordicIdx;
                    if (!p.cz[31])
                    begin
                        stage_next[k].cx = p.cx - dx;
                        stage_next[k].cy = p.cy + dy;
                        stage_next[k].cz = p.cz - bmg_pkg::atan_entry(5'(CordicIdx));
                    end
                    else
                    begin
                        stage_next[k].cx = p.cx + dx;
                        stage_next[k].cy = p.cy - dy;
                        stage_next[k].cz = p.cz + bmg_pkg::atan_entry(5'(CordicIdx));
                    end
                end

                if (k == bmg_pkg::SineStage)
                begin
                    case (p.quad)
                        bmg_pkg::QuadFirst:  stage_next[k].sine = 33'(p.cy);
                        bmg_pkg::QuadSecond: stage_next[k].sine = 33'(p.cx);
                        bmg_pkg::QuadThird:  stage_next[k].sine = -(33'(p.cy));
                        bmg_pkg::QuadFourth: stage_next[k].sine = -(33'(p.cx));
                        default:             stage_next[k].sine = '0;
                    endcase
                end

                if (k >= bmg_pkg::LogFirst && k <= bmg_pkg::LogLast)
                begin
                    // One fraction bit of log2 per stage by squaring.
                    sq = 64'(p.lx) * 64'(p.lx);
                    tq = sq[63:31];
                    if (tq[32])
                    begin
                        stage_next[k].lx           = tq[32:1];
                        stage_next[k].frac[LogBit] = 1'b1;
                    end
                    else
                    begin
                        stage_next[k].lx = tq[31:0];
                    end
                end

                if (k == bmg_pkg::LnStage)
                begin
                    lo = 32'd0 - p.frac;
                    lh = p.ipart - 6'(p.frac != 32'd0);
                    stage_next[k].ph = 38'(lh) * 38'(bmg_pkg::Ln2Q32);
                    stage_next[k].pl = 64'(lo) * 64'(bmg_pkg::Ln2Q32);
                end

                if (k == bmg_pkg::ScaleStage)
                begin
                    w = 40'({p.ph, 1'b0}) + 40'(p.pl[63:31]);
                    stage_next[k].sv   = {w[37:0], 24'd0};
                    stage_next[k].sres = '0;
                end

                if (k >= bmg_pkg::SqrtFirst && k <= bmg_pkg::SqrtLast)
                begin
                    // One root bit per stage.
                    trial = p.sres + SqrtBit;
                    if (p.sv >= trial)
                    begin
                        stage_next[k].sv   = p.sv - trial;
                        stage_next[k].sres = (p.sres >> 1) + SqrtBit;
                    end
                    else
                    begin
                        stage_next[k].sres = p.sres >> 1;
                    end
                end

                if (k == bmg_pkg::ZStage)
                begin
                    zp = 66'($signed({1'b0, p.sres[31:0]})) * 66'(p.sine);
                    stage_next[k].z = zp[63:30];
                end

                if (k == bmg_pkg::SigmaStage)
                begin
                    stage_next[k].prod = 66'($signed({1'b0, sigma_reg})) * 66'(p.z);
                end

                if (k == bmg_pkg::RoundStage)
                begin
                    rs = p.prod + bmg_pkg::RoundHalf;
                    stage_next[k].t = rs[65:28];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                if (k == 0)
                begin
                    stage_valid_reg[k] <= uniforms.valid;
                end
                else
                begin
                    stage_valid_reg[k] <= stage_valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Final add of the mean with saturation, or the rounded passthrough.
    always_comb
    begin
        logic signed [38:0] sum;
        logic [33:0]        pass;
        bmg_pkg::stage_t    p;
        p    = stage_reg[bmg_pkg::LastStage];
        sum  = 39'(mean_reg) + 39'(p.t);
        pass = (34'({p.k1, 1'b1}) + (34'd1 << (32 - bmg_pkg::FracBits)))
               >> (33 - bmg_pkg::FracBits);
        out_sat_next = 1'b0;
        if (!mode_reg)
        begin
            out_sample_next = $signed(pass[31:0]);
        end
        else if (sum > 39'sd2147483647)
        begin
            out_sample_next = 32'sh7FFFFFFF;
            out_sat_next    = 1'b1;
        end
        else if (sum < -39'sd2147483648)
        begin
            out_sample_next = 32'sh80000000;
            out_sat_next    = 1'b1;
        end
        else
        begin
            out_sample_next = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage_valid_reg[bmg_pkg::LastStage])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (samples.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid_reg[bmg_pkg::LastStage])
        begin
            out_sample_reg <= out_sample_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    // The normalized mantissa always has its top bit set.
    `BMG_ASSERT_IMPL(a_norm_msb, stage_valid_reg[bmg_pkg::NormStage], stage_reg[bmg_pkg::NormStage].lx[31], "log mantissa not normalized")
    // The square root of a value below 2^62 fits in 31 bits.
    `BMG_ASSERT_IMPL(a_sqrt_range, stage_valid_reg[bmg_pkg::SqrtLast], stage_reg[bmg_pkg::SqrtLast].sres[63:31] == 33'd0, "square root out of range")
    // A clipped sample sits on one of the two limits.
    `BMG_ASSERT_IMPL(a_sat_limit, out_valid_reg && out_sat_reg, out_sample_reg == 32'sh7FFFFFFF || out_sample_reg == 32'sh80000000, "saturated sample off the limits")
    // Passthrough results never carry the clip flag.
    `BMG_ASSERT_NEXT(a_pass_nosat, advance && stage_valid_reg[bmg_pkg::LastStage] && !mode_reg, !out_sat_reg, "passthrough item flagged as clipped")
    // A blocked output keeps the last stage's item in place.
    `BMG_ASSERT_NEXT(a_hold_last, stage_valid_reg[bmg_pkg::LastStage] && out_valid_reg && !samples.ready, stage_valid_reg[bmg_pkg::LastStage] && out_valid_reg, "item lost while output stalled")

endmodule

[sim/bmg_tb_if.sv]
// Constants shared by the sampler testbench.
package bmg_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;
    localparam int LatencyCycles = 71;
endpackage

[sim/bmg_checker.sv]
// Checker that predicts each sample of the Box-Muller sampler and compares it.
module bmg_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [bmg_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [bmg_pkg::CfgDataWidth-1:0]  cfg_data,
    bmg_in_if           uniforms,
    bmg_out_if          samples,
    output int          error_count,
    output int          pending_count,
    output logic        accepted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               clipped;
    } sample_exp_t;

    sample_exp_t expected_samples[$];
    logic        mode_reg;
    logic [31:0] mean_reg;
    logic [30:0] sigma_reg;

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [63:0] neg_two_ln(input logic [63:0] m);
        int unsigned e;
        logic [63:0] x, frac, big, lo, lh;
        e = 0;
        frac = 0;
        while (e < 32 && (m >> (e + 1)) != 0)
            e++;
        if (e <= 31)
            x = m << (31 - e);
        else
            x = m >> 1;
        for (int i = 31; i >= 0; i--)
        begin
            x = (x * x) >> 31;
            if (x >= 64'h1_0000_0000)
            begin
                x = x >> 1;
                frac[i] = 1'b1;
            end
        end
        big = ({32'd0, 32'(33 - e)} << 32) - frac;
        lh = big >> 32;
        lo = big & 64'hFFFF_FFFF;
        return ((lh * 64'(bmg_pkg::Ln2Q32)) << 1) + ((lo * 64'(bmg_pkg::Ln2Q32)) >> 31);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint phase_sine(input logic [63:0] p);
        logic [1:0]  quad;
        logic [63:0] r;
        longint x, y, a, dx, dy;
        quad = p[32:31];
        r = p & 64'h7FFF_FFFF;
        x = bmg_pkg::CordicGain;
        y = 0;
        a = longint'((r * 64'(bmg_pkg::HalfPiQ30)) >> 31);
        for (int i = 0; i < 30; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (a >= 0)
            begin
                x = x - dx;
                y = y + dy;
                a = a - bmg_pkg::atan_entry(5'(i));
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                a = a + bmg_pkg::atan_entry(5'(i));
            end
        end
        case (bmg_pkg::quad_t'(quad))
            bmg_pkg::QuadFirst:  return y;
            bmg_pkg::QuadSecond: return x;
            bmg_pkg::QuadThird:  return -y;
            default:             return -x;
        endcase
    endfunction

    function automatic sample_exp_t predict_sample(input logic [31:0] k1, input logic [31:0] k2);
        logic [63:0] m1, p2;
        longint s, z, t, res;
        sample_exp_t e;
        m1 = {31'd0, k1, 1'b1};
        p2 = {31'd0, k2, 1'b1};
        e.clipped = 1'b0;
        if (!mode_reg)
        begin
            e.sample = 32'((m1 + (64'd1 << (32 - bmg_pkg::FracBits)))
                           >> (33 - bmg_pkg::FracBits));
            return e;
        end
        s = longint'(int_sqrt(neg_two_ln(m1) << 24));
        z = floor_shift(s * phase_sine(p2), 30);
        t = floor_shift(longint'(sigma_reg) * z + (64'sd1 <<< 27), 28);
        res = longint'($signed(mean_reg)) + t;
        if (res > 64'sd2147483647)
        begin
            res = 64'sd2147483647;
            e.clipped = 1'b1;
        end
        else if (res < -64'sd2147483648)
        begin
            res = -64'sd2147483648;
            e.clipped = 1'b1;
        end
        e.sample = 32'(res);
        return e;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    assign pending_count = expected_samples.size();
    assign accepted = (uniforms.valid && uniforms.ready) || (samples.valid && samples.ready);

    always @(posedge clk or negedge rst_n)
    begin
        sample_exp_t e;
        if (!rst_n)
        begin
            mode_reg = 1'b0;
            mean_reg = '0;
            sigma_reg = bmg_pkg::SigmaReset;
            error_count = 0;
            expected_samples.delete();
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("sample with nothing expected");
                else
                begin
                    e = expected_samples.pop_front();
                    if (samples.sample_value !== e.sample)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                            samples.sample_value, e.sample));
                    if (samples.saturated_flag !== e.clipped)
                        report_mismatch($sformatf("clip flag %b, expected %b",
                            samples.saturated_flag, e.clipped));
                end
            end
            if (uniforms.valid && uniforms.ready)
                expected_samples.push_back(
                    predict_sample(uniforms.uniform_first, uniforms.uniform_second));
            if (cfg_write)
            begin
                if (cfg_index == bmg_pkg::RegOutputMode)
                    mode_reg = cfg_data[0];
                else if (cfg_index == bmg_pkg::RegMeanValue)
                    mean_reg = cfg_data;
                else if (cfg_index == bmg_pkg::RegStdDeviation)
                    sigma_reg = cfg_data[30:0];
            end
        end
    end
endmodule

[sim/testbench.sv]
// Top of the sampler testbench: clock, reset, stimulus, idling and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = bmg_tb_pkg::LatencyCycles;
    localparam int StallLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [bmg_pkg::CfgIndexWidth-1:0] cfg_index = bmg_pkg::RegOutputMode;
    logic [bmg_pkg::CfgDataWidth-1:0]  cfg_data = '0;

    bmg_in_if  uniforms();
    bmg_out_if samples();

    int   error_count;
    int   pending_count;
    logic accepted;

    // Idling percentages for the sender and the receiver, set per phase.
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    // While set, the receiver refuses every item for a long stretch.
    logic recv_hold = 1'b0;

    box_muller_gaussian_sampler_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .uniforms(uniforms.sink),
        .samples(samples.source)
    );

    bmg_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .uniforms(uniforms),
        .samples(samples),
        .error_count(error_count),
        .pending_count(pending_count),
        .accepted(accepted)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        uniforms.valid = 1'b0;
        uniforms.uniform_first = '0;
        uniforms.uniform_second = '0;
        samples.ready = 1'b0;
    end

    // The receiver draws its ready once per cycle, so stalls land on every pipeline phase.
    always @(posedge clk)
    begin
        if (rst_n)
            samples.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // The watchdog ends the run when nothing moves on either channel for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (accepted)
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one item and holds it until the block takes it, with random gaps before.
    // Valid stays high after the handshake so that items can follow back to back;
    // a gap or a drain lowers it.
    task automatic send_item(input logic [31:0] k1, input logic [31:0] k2);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            uniforms.valid <= 1'b0;
            @(posedge clk);
        end
        uniforms.valid <= 1'b1;
        uniforms.uniform_first <= k1;
        uniforms.uniform_second <= k2;
        do
            @(posedge clk);
        while (!uniforms.ready);
    endtask

    // Stops offering, waits until every expected sample has arrived, then lets
    // the pipeline drain fully.
    task automatic drain_samples();
        uniforms.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (Latency + 4)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [bmg_pkg::CfgIndexWidth-1:0] idx,
                                  input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [31:0] mean, input logic [31:0] sigma);
        drain_samples();
        write_register(bmg_pkg::RegOutputMode, {31'd0, mode});
        write_register(bmg_pkg::RegMeanValue, mean);
        write_register(bmg_pkg::RegStdDeviation, sigma);
        cfg_write <= 1'b0;
    endtask

    // Random codes lean on the extremes of the uniform range a fair part of the time.
    function automatic logic [31:0] random_code();
        case ($urandom_range(7))
            0:       return $urandom_range(255);
            1:       return 32'hFFFF_FFFF - $urandom_range(255);
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_code(), random_code());
    endtask

    // One pass of random items through the four idling phases.
    task automatic idling_phases(input int per_phase);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_items(per_phase);
        send_idle_pct = 77;
        random_items(per_phase);
        send_idle_pct = 0;
        recv_stall_pct = 77;
        random_items(per_phase);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        random_items(per_phase);
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        int timeout;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at reset settings: passthrough of the extreme codes.
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0000_7FFF, 32'h0000_8000);

        // Normal mode, unit sigma: the smallest uniform gives the largest radius,
        // and the phase codes land on every quadrant edge.
        configure(1'b1, 32'd0, 32'd65536);
        send_item(32'h0000_0000, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h4000_0000);
        send_item(32'h0000_0000, 32'h8000_0000);
        send_item(32'h0000_0000, 32'hC000_0000);
        send_item(32'hFFFF_FFFF, 32'h3FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h8000_0000, 32'h2000_0000);
        send_item(32'h7FFF_FFFF, 32'hDFFF_FFFF);

        // Largest sigma with an extreme mean forces saturation on both sides; zero sigma then returns the mean.
        configure(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h0000_0000, 32'h4000_0000);
        send_item(32'h0000_0000, 32'hC000_0000);
        configure(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h0000_0000, 32'h4000_0000);
        send_item(32'h0000_0000, 32'hC000_0000);
        configure(1'b1, 32'h1234_5678, 32'd0);
        send_item(32'h0000_0001, 32'h4000_0000);

        // The sender pauses here until every expected sample has come.
        configure(1'b1, 32'hFFF0_0000, 32'd200000);
        idling_phases(110);

        // The receiver holds off for a long stretch while the sender keeps offering,
        // so the pipeline fills and the input stalls.
        fork
            begin
                recv_hold = 1'b1;
                repeat (400)
                    @(posedge clk);
                recv_hold = 1'b0;
            end
            random_items(250);
        join

        configure(1'b0, 32'h5555_AAAA, 32'h0000_0001);
        idling_phases(60);
        configure(1'b1, 32'h0010_0000, 32'h00FF_FFFF);
        idling_phases(80);
        configure(1'b1, $urandom, $urandom & 32'h0003_FFFF);
        idling_phases(60);
        configure(1'b1, 32'd0, 32'd65536);
        idling_phases(60);

        // Let the last samples through, with a bound on the wait.
        uniforms.valid <= 1'b0;
        timeout = 0;
        while (pending_count != 0 && timeout < 100000)
        begin
            @(posedge clk);
            timeout++;
        end
        repeat (Latency + 4)
            @(posedge clk);
        if (pending_count == 0 && error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
